// ===== src/bgr_ycc_pkg.sv =====
// ----------------------------------------------------------------------------
// bgr_ycc_pkg
// Types and constants for the BGR pixel-pair to YCbCr 4:2:0 converter.
// ----------------------------------------------------------------------------
`default_nettype none

package bgr_ycc_pkg;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_PAIRS_PER_ROW  = 1'b0,
    CFG_ROW_PAIR_COUNT = 1'b1
  } cfg_reg_e;

  localparam int unsigned CfgDataW = 12;

  localparam logic [CfgDataW-1:0] PairsPerRowRst  = 12'd960;
  localparam logic [CfgDataW-1:0] RowPairCountRst = 12'd540;

  // row groups per frame are capped at this count
  localparam int unsigned MaxRowGroups = 2048;
  localparam int unsigned GroupW       = 11;

  // bt.601 studio-range coefficients, 8 fractional bits
  localparam logic [15:0] KLumaR   = 16'd66;
  localparam logic [15:0] KLumaG   = 16'd129;
  localparam logic [15:0] KLumaB   = 16'd25;
  localparam logic [15:0] KCbR     = 16'd38;   // subtracted
  localparam logic [15:0] KCbG     = 16'd74;   // subtracted
  localparam logic [15:0] KCbB     = 16'd112;
  localparam logic [15:0] KCrR     = 16'd112;
  localparam logic [15:0] KCrG     = 16'd94;   // subtracted
  localparam logic [15:0] KCrB     = 16'd18;   // subtracted
  localparam logic [15:0] RoundBias = 16'd128;
  localparam logic [7:0]  LumaOffset   = 8'd16;
  localparam logic [7:0]  ChromaOffset = 8'd128;

  typedef struct packed {
    logic [7:0] blue_first;
    logic [7:0] green_first;
    logic [7:0] red_first;
    logic [7:0] blue_second;
    logic [7:0] green_second;
    logic [7:0] red_second;
  } pair_in_t;

  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] luma_second;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
    logic       chroma_valid;
    logic       row_end;
    logic       frame_end;
  } pair_out_t;

endpackage

`default_nettype wire

// ===== src/bgr_to_ycbcr_420_converter_core.sv =====
// ----------------------------------------------------------------------------
// bgr_to_ycbcr_420_converter_core
// BGR pixel pairs in, BT.601 studio-range luma pairs out, with 4:2:0 chroma
// from even rows and row / frame end markers.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+----------------------------
//  in      | in        | in_valid_i / in_ready_o  | in_data_i  (pair_in_t)
//  out     | out       | out_valid_o / out_ready_i| out_data_o (pair_out_t)
//  cfg     | in        | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
//  one request is taken every clock while the output is not stalled; a
//  result passes the capture stage, then the result stage, and is then
//  valid on out_valid_o / out_data_o
//  the rate is set by the two-entry pipeline: each stage moves on when the
//  one after it is empty or drains in the same cycle
//  reset clears the counters, the pipeline valid bits and loads the
//  register defaults (960 pairs per row, 540 row groups)
//  configuration writes are always taken
//
`default_nettype none

module bgr_to_ycbcr_420_converter_core
  import bgr_ycc_pkg::*;
#(
  parameter int unsigned MAX_PAIRS_PER_ROW = 2048
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // pixel pair requests
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire pair_in_t            in_data_i,
  // results
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output pair_out_t                out_data_o,
  // configuration writes
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire cfg_reg_e            cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  // column counter only needs to reach the largest last column
  localparam int unsigned ColW = (MAX_PAIRS_PER_ROW > 1) ? $clog2(MAX_PAIRS_PER_ROW) : 1;
  // compare width wide enough for both the register and the cap
  localparam int unsigned CapW = $clog2(MAX_PAIRS_PER_ROW + 1);
  localparam int unsigned CmpW = (CapW > CfgDataW) ? CapW : CfgDataW;
  localparam logic [CmpW-1:0] ColCap = CmpW'(MAX_PAIRS_PER_ROW);
  localparam logic [CfgDataW-1:0] GroupCap = CfgDataW'(MaxRowGroups);

  // --------------------------------------------------------------------------
  // arithmetic helpers
  // --------------------------------------------------------------------------
  function automatic logic [7:0] luma_of(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
    logic [15:0] acc;
    acc = KLumaR * {8'd0, r} + KLumaG * {8'd0, g} + KLumaB * {8'd0, b} + RoundBias;
    return acc[15:8] + LumaOffset;
  endfunction

  // modulo 2^16 arithmetic; the true sum plus the offset bias is always
  // positive and below 2^16, so bits 15:8 give the offset chroma directly
  function automatic logic [7:0] chroma_of(input logic [15:0] pr, input logic [15:0] pg,
                                           input logic [15:0] pb,
                                           input logic [15:0] nr, input logic [15:0] ng,
                                           input logic [15:0] nb);
    logic [15:0] acc;
    acc = pr + pg + pb - nr - ng - nb + RoundBias + {ChromaOffset, 8'd0};
    return acc[15:8];
  endfunction

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [CfgDataW-1:0] pairs_per_row_q;
  logic [CfgDataW-1:0] row_pair_count_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pairs_per_row_q  <= PairsPerRowRst;
      row_pair_count_q <= RowPairCountRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_PAIRS_PER_ROW:  pairs_per_row_q  <= cfg_data_i;
        CFG_ROW_PAIR_COUNT: row_pair_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective sizes: zero acts as one, oversize acts as the cap
  logic [CmpW-1:0]     ppr_wide;
  logic [CmpW-1:0]     cols_eff;
  logic [ColW-1:0]     col_last;
  logic [CfgDataW-1:0] rows_eff;
  logic [GroupW-1:0]   group_last;

  assign ppr_wide = CmpW'(pairs_per_row_q);

  always_comb begin
    if (ppr_wide == '0) begin
      cols_eff = CmpW'(1);
    end else if (ppr_wide > ColCap) begin
      cols_eff = ColCap;
    end else begin
      cols_eff = ppr_wide;
    end
    col_last = ColW'(cols_eff - CmpW'(1));

    if (row_pair_count_q == '0) begin
      rows_eff = CfgDataW'(1);
    end else if (row_pair_count_q > GroupCap) begin
      rows_eff = GroupCap;
    end else begin
      rows_eff = row_pair_count_q;
    end
    group_last = GroupW'(rows_eff - CfgDataW'(1));
  end

  // --------------------------------------------------------------------------
  // pipeline handshake
  // --------------------------------------------------------------------------
  logic s1_valid_q;
  logic out_valid_q;
  logic s2_en;
  logic s1_en;
  logic in_fire;

  assign s2_en      = !out_valid_q || out_ready_i;
  assign s1_en      = !s1_valid_q || s2_en;
  assign in_ready_o = s1_en;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_en) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // --------------------------------------------------------------------------
  // position counters, advanced on every accepted request
  // --------------------------------------------------------------------------
  logic [ColW-1:0]   column_q,  column_d;
  logic              odd_row_q, odd_row_d;
  logic [GroupW-1:0] group_q,   group_d;
  logic              row_last;
  logic              frame_last;

  // a counter at or past the last position (register lowered) ends here
  assign row_last   = column_q >= col_last;
  assign frame_last = row_last && odd_row_q && (group_q >= group_last);

  always_comb begin
    column_d  = column_q;
    odd_row_d = odd_row_q;
    group_d   = group_q;
    if (!row_last) begin
      column_d = column_q + ColW'(1);
    end else begin
      column_d  = '0;
      odd_row_d = !odd_row_q;
      if (odd_row_q) begin
        group_d = frame_last ? '0 : group_q + GroupW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q  <= '0;
      odd_row_q <= 1'b0;
      group_q   <= '0;
    end else if (in_fire) begin
      column_q  <= column_d;
      odd_row_q <= odd_row_d;
      group_q   <= group_d;
    end
  end

  // --------------------------------------------------------------------------
  // capture stage: pixels and their position flags
  // --------------------------------------------------------------------------
  pair_in_t s1_pix_q;
  logic     s1_odd_q;
  logic     s1_row_end_q;
  logic     s1_frame_end_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pix_q       <= in_data_i;
      s1_odd_q       <= odd_row_q;
      s1_row_end_q   <= row_last;
      s1_frame_end_q <= frame_last;
    end
  end

  // --------------------------------------------------------------------------
  // result stage: colour conversion
  // --------------------------------------------------------------------------
  logic [8:0]  sum_b, sum_g, sum_r;
  logic [15:0] avg_b, avg_g, avg_r;
  pair_out_t   res_d;
  pair_out_t   res_q;

  always_comb begin
    // truncated pair average per channel
    sum_b = {1'b0, s1_pix_q.blue_first}  + {1'b0, s1_pix_q.blue_second};
    sum_g = {1'b0, s1_pix_q.green_first} + {1'b0, s1_pix_q.green_second};
    sum_r = {1'b0, s1_pix_q.red_first}   + {1'b0, s1_pix_q.red_second};
    avg_b = {8'd0, sum_b[8:1]};
    avg_g = {8'd0, sum_g[8:1]};
    avg_r = {8'd0, sum_r[8:1]};

    res_d.luma_first  = luma_of(s1_pix_q.red_first, s1_pix_q.green_first,
                                s1_pix_q.blue_first);
    res_d.luma_second = luma_of(s1_pix_q.red_second, s1_pix_q.green_second,
                                s1_pix_q.blue_second);
    if (!s1_odd_q) begin
      res_d.chroma_blue  = chroma_of(16'd0, 16'd0, KCbB * avg_b,
                                     KCbR * avg_r, KCbG * avg_g, 16'd0);
      res_d.chroma_red   = chroma_of(KCrR * avg_r, 16'd0, 16'd0,
                                     16'd0, KCrG * avg_g, KCrB * avg_b);
      res_d.chroma_valid = 1'b1;
    end else begin
      // odd rows carry neutral chroma
      res_d.chroma_blue  = ChromaOffset;
      res_d.chroma_red   = ChromaOffset;
      res_d.chroma_valid = 1'b0;
    end
    res_d.row_end   = s1_row_end_q;
    res_d.frame_end = s1_frame_end_q;
  end

  always_ff @(posedge clk_i) begin
    if (s2_en && s1_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

endmodule

`default_nettype wire
